[rtl/core/phup_pkg.sv]
// phup_pkg: shared sizes, codes and struct types of the probed hash unit pool
// used by phup_ctrl, phup_dpath and probed_hash_unit_pool_top; no dependencies
package phup_pkg;

	// table geometry
	localparam int TABLE_SIZE = 8;
	localparam int IDX_W      = $clog2(TABLE_SIZE);
	localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
	localparam int REM_W      = IDX_W + 1;

	// field widths
	localparam int CMD_W = 3;
	localparam int KEY_W = 31;
	localparam int CAP_W = 8;
	localparam int ST_W  = 3;

	// home slot reduction: key mod TABLE_SIZE, MOD_BITS key bits per cycle
	localparam int MOD_BITS  = 8;
	localparam int MOD_STEPS = (KEY_W + MOD_BITS - 1) / MOD_BITS;
	localparam int MOD_W     = MOD_STEPS * MOD_BITS;
	localparam int MCNT_W    = $clog2(MOD_STEPS + 1);

	localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(TABLE_SIZE - 1);
	localparam logic [CNT_W-1:0]  CNT_TS   = CNT_W'(TABLE_SIZE);
	localparam logic [REM_W-1:0]  REM_TS   = REM_W'(TABLE_SIZE);
	localparam logic [MCNT_W-1:0] MCNT_END = MCNT_W'(MOD_STEPS);

	// request commands
	localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_LOOKUP   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DISPATCH = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RELEASE  = 3'd4;

	// response status
	localparam logic [ST_W-1:0] ST_OK        = 3'd0;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd1;
	localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
	localparam logic [ST_W-1:0] ST_DUP       = 3'd3;
	localparam logic [ST_W-1:0] ST_NONE      = 3'd4;

	// finish actions chosen by the controller
	localparam int FIN_W = 4;
	localparam logic [FIN_W-1:0] FIN_OK_ZERO   = 4'd0;
	localparam logic [FIN_W-1:0] FIN_FULL      = 4'd1;
	localparam logic [FIN_W-1:0] FIN_DUP       = 4'd2;
	localparam logic [FIN_W-1:0] FIN_NOT_FOUND = 4'd3;
	localparam logic [FIN_W-1:0] FIN_CLEAR     = 4'd4;
	localparam logic [FIN_W-1:0] FIN_INSERT    = 4'd5;
	localparam logic [FIN_W-1:0] FIN_LOOKUP    = 4'd6;
	localparam logic [FIN_W-1:0] FIN_RELEASE   = 4'd7;
	localparam logic [FIN_W-1:0] FIN_DISPATCH  = 4'd8;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [KEY_W-1:0] key;
		logic [CAP_W-1:0] capacity;
		logic [CAP_W-1:0] initial_available;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [KEY_W-1:0] unit_key;
		logic [CAP_W-1:0] unit_capacity;
		logic [CAP_W-1:0] unit_available;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic             ld;
		logic             mod_start;
		logic             mod_step;
		logic             scan_home;
		logic             scan_zero;
		logic             rd_en;
		logic             fin_go;
		logic [FIN_W-1:0] fin;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [CMD_W-1:0] op;
		logic             key_zero;
		logic             tbl_full;
		logic             mod_done;
		logic             chk_valid;
		logic             chk_used;
		logic             chk_key_eq;
		logic             scan_end;
		logic             out_free;
	} dp_sts_t;

endpackage

[rtl/core/probed_hash_unit_pool_top.sv]
// probed_hash_unit_pool_top: one request at a time. Clear, release of key zero, insert into a
// full table and unknown commands visit no slot; dispatch visits every slot, release up to every
// slot, and insert and lookup run the home slot reduction and then visit up to every slot, with
// the single slot read port visiting one slot per cycle.
// The next request is taken once the result sits in the output register.
// Reset clears the occupancy bits, entry count and control state; slot contents are not cleared.
module probed_hash_unit_pool_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  phup_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output phup_pkg::rsp_t rsp
);

	phup_pkg::dp_cmd_t cmd;
	phup_pkg::dp_sts_t sts;

	phup_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	phup_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	// a result is only loaded into a free output register
	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin_go |-> sts.out_free)
		else $error("result loaded over a pending result");

	// no slot read past a full sweep
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> !sts.scan_end)
		else $error("slot read beyond table size");

	// insert never places into a full table
	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fin_go && (cmd.fin == phup_pkg::FIN_INSERT)) |-> !sts.tbl_full)
		else $error("insert into full table");

	// a new result appears only after a finish
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(cmd.fin_go))
		else $error("result without finish");

endmodule

[rtl/core/phup_dpath.sv]
// phup_dpath: slot storage, home slot reduction, probe pointer, dispatch
// candidates and response register; depends on phup_pkg
module phup_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  phup_pkg::req_t    req,
	input  phup_pkg::dp_cmd_t cmd,
	output phup_pkg::dp_sts_t sts,
	input  logic              rsp_ready,
	output logic              rsp_valid,
	output phup_pkg::rsp_t    rsp
);

	// slot memories, read one slot per cycle during a scan
	logic [phup_pkg::KEY_W-1:0] mem_key [phup_pkg::TABLE_SIZE];
	logic [phup_pkg::CAP_W-1:0] mem_cap [phup_pkg::TABLE_SIZE];
	logic [phup_pkg::CAP_W-1:0] mem_av  [phup_pkg::TABLE_SIZE];

	phup_pkg::req_t                  req_q;
	logic [phup_pkg::TABLE_SIZE-1:0] used_q;
	logic [phup_pkg::CNT_W-1:0]      count_q;

	logic [phup_pkg::MOD_W-1:0]  mod_sh_q;
	logic [phup_pkg::IDX_W-1:0]  rem_q;
	logic [phup_pkg::MCNT_W-1:0] mod_cnt_q;
	logic [phup_pkg::REM_W-1:0]  rem_nxt;

	logic [phup_pkg::IDX_W-1:0] ptr_q;
	logic [phup_pkg::CNT_W-1:0] scnt_q;

	logic                       chk_valid_s1;
	logic                       rd_used_s1;
	logic [phup_pkg::IDX_W-1:0] rd_idx_s1;
	logic [phup_pkg::KEY_W-1:0] rd_key_s1;
	logic [phup_pkg::CAP_W-1:0] rd_cap_s1;
	logic [phup_pkg::CAP_W-1:0] rd_av_s1;

	logic                       pref_seen_q;
	logic [phup_pkg::IDX_W-1:0] pref_idx_q;
	logic [phup_pkg::CAP_W-1:0] pref_av_q;
	logic                       any_seen_q;
	logic [phup_pkg::IDX_W-1:0] any_idx_q;
	logic [phup_pkg::KEY_W-1:0] any_key_q;
	logic [phup_pkg::CAP_W-1:0] any_av_q;

	phup_pkg::rsp_t rsp_q;
	phup_pkg::rsp_t rsp_nxt;
	logic           rsp_valid_q;

	logic                       key_eq;
	logic                       pref_ok;
	logic [phup_pkg::CAP_W-1:0] av_inc;
	logic                       want_all;
	logic                       want_av;
	logic                       wr_all;
	logic                       wr_av;
	logic [phup_pkg::IDX_W-1:0] wr_idx;
	logic [phup_pkg::CAP_W-1:0] wr_av_data;

	// request latch
	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			req_q <= req;
		end
	end

	// home slot: remainder update over MOD_BITS key bits, msb first
	always_comb begin
		rem_nxt = {1'b0, rem_q};
		for (int j = 0; j < phup_pkg::MOD_BITS; j++) begin
			rem_nxt = {rem_nxt[phup_pkg::REM_W-2:0], mod_sh_q[phup_pkg::MOD_W-1-j]};
			if (rem_nxt >= phup_pkg::REM_TS) begin
				rem_nxt = rem_nxt - phup_pkg::REM_TS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_cnt_q <= '0;
		end else if (cmd.mod_start) begin
			mod_cnt_q <= '0;
		end else if (cmd.mod_step) begin
			mod_cnt_q <= mod_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mod_start) begin
			mod_sh_q <= phup_pkg::MOD_W'(req_q.key);
			rem_q    <= '0;
		end else if (cmd.mod_step) begin
			mod_sh_q <= mod_sh_q << phup_pkg::MOD_BITS;
			rem_q    <= rem_nxt[phup_pkg::IDX_W-1:0];
		end
	end

	// probe pointer and visit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			scnt_q       <= '0;
			chk_valid_s1 <= 1'b0;
		end else begin
			chk_valid_s1 <= cmd.rd_en;
			if (cmd.scan_home || cmd.scan_zero) begin
				ptr_q  <= cmd.scan_home ? rem_q : '0;
				scnt_q <= '0;
			end else if (cmd.rd_en) begin
				ptr_q  <= (ptr_q == phup_pkg::IDX_LAST) ? '0 : ptr_q + 1'b1;
				scnt_q <= scnt_q + 1'b1;
			end
		end
	end

	// slot read stage and writes at finish
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_key_s1  <= mem_key[ptr_q];
			rd_cap_s1  <= mem_cap[ptr_q];
			rd_av_s1   <= mem_av[ptr_q];
			rd_used_s1 <= used_q[ptr_q];
			rd_idx_s1  <= ptr_q;
		end
		if (wr_all) begin
			mem_key[wr_idx] <= req_q.key;
			mem_cap[wr_idx] <= req_q.capacity;
		end
		if (wr_av) begin
			mem_av[wr_idx] <= wr_av_data;
		end
	end

	assign key_eq = (rd_key_s1 == req_q.key);

	// dispatch candidates: first used slot with the preferred key, first with units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pref_seen_q <= 1'b0;
			any_seen_q  <= 1'b0;
		end else if (cmd.scan_home || cmd.scan_zero) begin
			pref_seen_q <= 1'b0;
			any_seen_q  <= 1'b0;
		end else if (chk_valid_s1) begin
			if (rd_used_s1 && key_eq && !pref_seen_q) begin
				pref_seen_q <= 1'b1;
			end
			if (rd_used_s1 && (rd_av_s1 != '0) && !any_seen_q) begin
				any_seen_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chk_valid_s1) begin
			if (rd_used_s1 && key_eq && !pref_seen_q) begin
				pref_idx_q <= rd_idx_s1;
				pref_av_q  <= rd_av_s1;
			end
			if (rd_used_s1 && (rd_av_s1 != '0) && !any_seen_q) begin
				any_idx_q <= rd_idx_s1;
				any_key_q <= rd_key_s1;
				any_av_q  <= rd_av_s1;
			end
		end
	end

	assign pref_ok = pref_seen_q && (pref_av_q != '0);
	assign av_inc  = (rd_av_s1 < rd_cap_s1) ? rd_av_s1 + 1'b1 : rd_av_s1;

	// response and slot update for the finish action
	always_comb begin
		rsp_nxt        = '0;
		rsp_nxt.status = phup_pkg::ST_OK;
		want_all       = 1'b0;
		want_av        = 1'b0;
		wr_idx         = rd_idx_s1;
		wr_av_data     = av_inc;
		case (cmd.fin)
			phup_pkg::FIN_FULL: begin
				rsp_nxt.status = phup_pkg::ST_FULL;
			end
			phup_pkg::FIN_DUP: begin
				rsp_nxt.status = phup_pkg::ST_DUP;
			end
			phup_pkg::FIN_NOT_FOUND: begin
				rsp_nxt.status = phup_pkg::ST_NOT_FOUND;
			end
			phup_pkg::FIN_INSERT: begin
				want_all               = 1'b1;
				want_av                = 1'b1;
				wr_av_data             = req_q.initial_available;
				rsp_nxt.unit_available = req_q.initial_available;
			end
			phup_pkg::FIN_LOOKUP: begin
				rsp_nxt.unit_key       = req_q.key;
				rsp_nxt.unit_capacity  = rd_cap_s1;
				rsp_nxt.unit_available = rd_av_s1;
			end
			phup_pkg::FIN_RELEASE: begin
				want_av                = 1'b1;
				rsp_nxt.unit_key       = req_q.key;
				rsp_nxt.unit_available = av_inc;
			end
			phup_pkg::FIN_DISPATCH: begin
				if (pref_ok) begin
					want_av                = 1'b1;
					wr_idx                 = pref_idx_q;
					wr_av_data             = pref_av_q - 1'b1;
					rsp_nxt.unit_key       = req_q.key;
					rsp_nxt.unit_available = pref_av_q - 1'b1;
				end else if (any_seen_q) begin
					want_av                = 1'b1;
					wr_idx                 = any_idx_q;
					wr_av_data             = any_av_q - 1'b1;
					rsp_nxt.unit_key       = any_key_q;
					rsp_nxt.unit_available = any_av_q - 1'b1;
				end else begin
					rsp_nxt.status = phup_pkg::ST_NONE;
				end
			end
			default: begin
			end
		endcase
	end

	assign wr_all = cmd.fin_go && want_all;
	assign wr_av  = cmd.fin_go && want_av;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			count_q <= '0;
		end else if (cmd.fin_go && (cmd.fin == phup_pkg::FIN_CLEAR)) begin
			used_q  <= '0;
			count_q <= '0;
		end else if (wr_all) begin
			used_q[rd_idx_s1] <= 1'b1;
			count_q           <= count_q + 1'b1;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.fin_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_go) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// status to the controller
	assign sts.op         = req_q.cmd;
	assign sts.key_zero   = (req_q.key == '0);
	assign sts.tbl_full   = (count_q >= phup_pkg::CNT_TS);
	assign sts.mod_done   = (mod_cnt_q == phup_pkg::MCNT_END);
	assign sts.chk_valid  = chk_valid_s1;
	assign sts.chk_used   = rd_used_s1;
	assign sts.chk_key_eq = key_eq;
	assign sts.scan_end   = (scnt_q == phup_pkg::CNT_TS);
	assign sts.out_free   = !rsp_valid_q || rsp_ready;

endmodule

[rtl/core/phup_ctrl.sv]
// phup_ctrl: request sequencer of the probed hash unit pool
// drives phup_dpath through dp_cmd_t and reads dp_sts_t; depends on phup_pkg
module phup_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  phup_pkg::dp_sts_t sts,
	output phup_pkg::dp_cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_HOME   = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	logic [2:0]                 state_q;
	logic [2:0]                 state_nxt;
	logic [phup_pkg::FIN_W-1:0] fin_q;
	logic [phup_pkg::FIN_W-1:0] fin_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fin_q   <= phup_pkg::FIN_OK_ZERO;
		end else begin
			state_q <= state_nxt;
			fin_q   <= fin_nxt;
		end
	end

	// next state and datapath commands
	always_comb begin
		logic term;
		term      = 1'b0;
		state_nxt = state_q;
		fin_nxt   = fin_q;
		req_ready = 1'b0;
		cmd       = '0;
		cmd.fin   = fin_q;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.ld    = 1'b1;
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.op)
					phup_pkg::CMD_INSERT: begin
						if (sts.tbl_full) begin
							fin_nxt   = phup_pkg::FIN_FULL;
							state_nxt = S_FINISH;
						end else begin
							cmd.mod_start = 1'b1;
							state_nxt     = S_HOME;
						end
					end
					phup_pkg::CMD_LOOKUP: begin
						cmd.mod_start = 1'b1;
						state_nxt     = S_HOME;
					end
					phup_pkg::CMD_CLEAR: begin
						fin_nxt   = phup_pkg::FIN_CLEAR;
						state_nxt = S_FINISH;
					end
					phup_pkg::CMD_DISPATCH: begin
						cmd.scan_zero = 1'b1;
						state_nxt     = S_SCAN;
					end
					phup_pkg::CMD_RELEASE: begin
						if (sts.key_zero) begin
							fin_nxt   = phup_pkg::FIN_OK_ZERO;
							state_nxt = S_FINISH;
						end else begin
							cmd.scan_zero = 1'b1;
							state_nxt     = S_SCAN;
						end
					end
					default: begin
						fin_nxt   = phup_pkg::FIN_OK_ZERO;
						state_nxt = S_FINISH;
					end
				endcase
			end
			S_HOME: begin
				if (sts.mod_done) begin
					cmd.scan_home = 1'b1;
					state_nxt     = S_SCAN;
				end else begin
					cmd.mod_step = 1'b1;
				end
			end
			S_SCAN: begin
				// stop on the slot that decides the request
				if (sts.chk_valid) begin
					case (sts.op)
						phup_pkg::CMD_INSERT: begin
							if (!sts.chk_used) begin
								term    = 1'b1;
								fin_nxt = phup_pkg::FIN_INSERT;
							end else if (sts.chk_key_eq) begin
								term    = 1'b1;
								fin_nxt = phup_pkg::FIN_DUP;
							end
						end
						phup_pkg::CMD_LOOKUP: begin
							if (!sts.chk_used) begin
								term    = 1'b1;
								fin_nxt = phup_pkg::FIN_NOT_FOUND;
							end else if (sts.chk_key_eq) begin
								term    = 1'b1;
								fin_nxt = phup_pkg::FIN_LOOKUP;
							end
						end
						phup_pkg::CMD_RELEASE: begin
							if (sts.chk_used && sts.chk_key_eq) begin
								term    = 1'b1;
								fin_nxt = phup_pkg::FIN_RELEASE;
							end
						end
						default: begin
						end
					endcase
				end else if (sts.scan_end) begin
					// every slot visited
					term = 1'b1;
					case (sts.op)
						phup_pkg::CMD_INSERT:   fin_nxt = phup_pkg::FIN_FULL;
						phup_pkg::CMD_LOOKUP:   fin_nxt = phup_pkg::FIN_NOT_FOUND;
						phup_pkg::CMD_RELEASE:  fin_nxt = phup_pkg::FIN_NOT_FOUND;
						phup_pkg::CMD_DISPATCH: fin_nxt = phup_pkg::FIN_DISPATCH;
						default:                fin_nxt = phup_pkg::FIN_OK_ZERO;
					endcase
				end
				if (term) begin
					state_nxt = S_FINISH;
				end else if (!sts.scan_end) begin
					cmd.rd_en = 1'b1;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.fin_go = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule
